// File: hw/rtl/sm2mm_pkg.sv
`default_nettype none
package sm2mm_pkg;

  // Operand and digit geometry: 256-bit operands scanned 32 bits per cell.
  localparam int OPW    = 256;
  localparam int DIGW   = 32;
  localparam int DIGITS = OPW / DIGW;
  // Running sum bound is below 2^256 + p, so two headroom bits.
  localparam int TW     = OPW + 2;
  // Each cell has two register stages, the final reduction two more.
  localparam int LATENCY = 2 * DIGITS + 2;

  localparam logic [OPW-1:0] PRIME =
    256'hFFFFFFFE_FFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFF_00000000_FFFFFFFF_FFFFFFFF;

  // Data that moves from one cell to the next.
  typedef struct packed {
    logic           vld;
    logic [OPW-1:0] x;
    logic [OPW-1:0] y;
    logic [TW-1:0]  t;
  } sm2mm_flow_t;

endpackage
`default_nettype wire

// File: hw/rtl/sm2mm_cell.sv
`default_nettype none
module sm2mm_cell import sm2mm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  sm2mm_flow_t flow_in,
  output sm2mm_flow_t flow_out
);

  localparam int SW = TW + DIGW;

  logic                a_vld;
  logic [OPW-1:0]      a_x;
  logic [OPW-1:0]      a_y;
  logic [TW-1:0]       a_t;
  logic [2*DIGW-1:0]   a_pp [DIGITS];
  logic [OPW-1:0]      evn;
  logic [OPW-1:0]      od;
  logic [SW-1:0]       s;
  logic [DIGW-1:0]     m;
  logic [TW-1:0]       t_next;

  // Stage A: the low x digit times each y digit, one multiplier per lane.
  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else begin
      a_vld <= flow_in.vld;
    end
  end

  always_ff @(posedge clk) begin
    a_x <= flow_in.x;
    a_y <= flow_in.y;
    a_t <= flow_in.t;
    for (int k = 0; k < DIGITS; k++) begin
      a_pp[k] <= {{DIGW{1'b0}}, flow_in.x[DIGW-1:0]} *
                 {{DIGW{1'b0}}, flow_in.y[DIGW*k +: DIGW]};
    end
  end

  // Stage B: add the digit product, then fold in m*p and drop one digit.
  // Since p is -1 mod 2^32, m is the low digit of the sum, and
  // (s + m*p) / 2^32 = s/2^32 + m*2^224 - m*2^192 - m*2^64 + m*2^32.
  always_comb begin
    for (int k = 0; k < DIGITS / 2; k++) begin
      evn[2*DIGW*k +: 2*DIGW] = a_pp[2*k];
      od[2*DIGW*k +: 2*DIGW]  = a_pp[2*k+1];
    end
    s = {{DIGW{1'b0}}, a_t} + {{(SW-OPW){1'b0}}, evn}
      + {{(SW-OPW-DIGW){1'b0}}, od, {DIGW{1'b0}}};
    m = s[DIGW-1:0];
    t_next = s[SW-1:DIGW]
           + {2'b0, m, 224'b0}
           - {34'b0, m, 192'b0}
           - {162'b0, m, 64'b0}
           + {194'b0, m, 32'b0};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      flow_out.vld <= 1'b0;
    end else begin
      flow_out.vld <= a_vld;
    end
  end

  always_ff @(posedge clk) begin
    flow_out.x <= {{DIGW{1'b0}}, a_x[OPW-1:DIGW]};
    flow_out.y <= a_y;
    flow_out.t <= t_next;
  end

endmodule
`default_nettype wire

// File: hw/rtl/sm2mm_reduce.sv
`default_nettype none
module sm2mm_reduce import sm2mm_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  input  logic           vld,
  input  logic [TW-1:0]  t,
  output logic           done,
  output logic [OPW-1:0] r
);

  logic           v_vld;
  logic [OPW-1:0] v;
  logic [OPW:0]   d;

  // First step: a sum at or above 2^256 loses p, modulo 2^256.
  always_ff @(posedge clk) begin
    if (rst) begin
      v_vld <= 1'b0;
    end else begin
      v_vld <= vld;
    end
  end

  always_ff @(posedge clk) begin
    v <= t[OPW] ? (t[OPW-1:0] - PRIME) : t[OPW-1:0];
  end

  // Second step: subtract p once more when no borrow comes out.
  assign d = {1'b0, v} - {1'b0, PRIME};

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= v_vld;
    end
  end

  always_ff @(posedge clk) begin
    r <= d[OPW] ? v : d[OPW-1:0];
  end

endmodule
`default_nettype wire

// File: hw/rtl/sm2_prime_montgomery_multiplier_core.sv
`default_nettype none
// Montgomery multiplier for the SM2 prime field, R = 2^256.
// An item is taken on a clock edge where start is high and busy is low; busy
// is always low, so an item can be given on every cycle. cmd selects x*y or
// x*x; operands come as four 64-bit limbs, least significant first.
// The result x*y*R^-1 mod p, fully reduced, appears on r_0..r_3 for exactly
// one cycle with done high. The pipeline is a chain of eight cells, one per
// 32-bit digit of x, each with a multiply stage and an accumulate-and-reduce
// stage, followed by two stages of conditional subtraction of p. Throughput
// is one item per cycle.
// Reset clears the valid bits of the pipeline, so items in flight are
// dropped and no result appears until a new item is taken. The receiver
// cannot stall; each result must be captured in its done cycle.
module sm2_prime_montgomery_multiplier_core import sm2mm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        cmd,
  input  logic [63:0] x_0,
  input  logic [63:0] x_1,
  input  logic [63:0] x_2,
  input  logic [63:0] x_3,
  input  logic [63:0] y_0,
  input  logic [63:0] y_1,
  input  logic [63:0] y_2,
  input  logic [63:0] y_3,
  output logic        done,
  output logic [63:0] r_0,
  output logic [63:0] r_1,
  output logic [63:0] r_2,
  output logic [63:0] r_3
);

  sm2mm_flow_t    flow [DIGITS+1];
  logic [OPW-1:0] res;

  assign busy = 1'b0;

  // Squaring feeds x into both operand paths.
  assign flow[0].vld = start;
  assign flow[0].x   = {x_3, x_2, x_1, x_0};
  assign flow[0].y   = cmd ? {x_3, x_2, x_1, x_0} : {y_3, y_2, y_1, y_0};
  assign flow[0].t   = '0;

  // Chain of digit cells.
  for (genvar i = 0; i < DIGITS; i++) begin : g_cell
    sm2mm_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .flow_in  (flow[i]),
      .flow_out (flow[i+1])
    );
  end

  sm2mm_reduce u_reduce (
    .clk  (clk),
    .rst  (rst),
    .vld  (flow[DIGITS].vld),
    .t    (flow[DIGITS].t),
    .done (done),
    .r    (res)
  );

  assign r_0 = res[63:0];
  assign r_1 = res[127:64];
  assign r_2 = res[191:128];
  assign r_3 = res[255:192];

`ifndef SYNTHESIS
  // Every result traces back to an item taken at the head of the pipeline.
  a_done_has_item: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, LATENCY))
    else $error("result without a matching item");

  // Every item taken gives a result; none is lost in the pipeline.
  a_item_gives_done: assert property (@(posedge clk) disable iff (rst)
    start |-> ##LATENCY done)
    else $error("item lost in the pipeline");

  // Results are fully reduced.
  a_reduced: assert property (@(posedge clk) disable iff (rst)
    done |-> ({r_3, r_2, r_1, r_0} < PRIME))
    else $error("result not below p");
`endif

endmodule
`default_nettype wire

// File: tb/sm2_prime_montgomery_multiplier_core_test.sv
`timescale 1ns / 100ps
module sm2_prime_montgomery_multiplier_core_test;
  import sm2mm_pkg::*;

  localparam logic CMD_MUL = 1'b0;
  localparam logic CMD_SQR = 1'b1;
  localparam logic [255:0] ALL_ONES = {256{1'b1}};

  typedef struct {
    logic         cmd;
    logic [255:0] x;
    logic [255:0] y;
    bit           typed;
    logic [255:0] product;
  } mont_row_t;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic        cmd;
  logic [63:0] x_0, x_1, x_2, x_3;
  logic [63:0] y_0, y_1, y_2, y_3;
  logic        done;
  logic [63:0] r_0, r_1, r_2, r_3;

  logic [255:0] pending_products[$];
  int           fail_count = 0;
  mont_row_t    directed_rows[$];

  sm2_prime_montgomery_multiplier_core i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd),
    .x_0(x_0), .x_1(x_1), .x_2(x_2), .x_3(x_3),
    .y_0(y_0), .y_1(y_1), .y_2(y_2), .y_3(y_3),
    .done(done), .r_0(r_0), .r_1(r_1), .r_2(r_2), .r_3(r_3)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Computes x * y * 2^-256 mod p with word-wise reduction; each word's factor
  // is the low word itself since p is -1 modulo 2^64.
  function automatic logic [255:0] mont_product(logic sq, logic [255:0] a, logic [255:0] b);
    logic [575:0] acc;
    logic [63:0]  m;
    logic [256:0] quot;
    logic [255:0] res;
    if (sq == CMD_SQR) b = a;
    acc = 576'(a) * 576'(b);
    for (int i = 0; i < 4; i++) begin
      m = acc[64*i +: 64];
      acc = acc + ((576'(m) * 576'(PRIME)) << (64 * i));
    end
    quot = acc[512:256];
    res = quot[255:0];
    if (quot[256]) res = res - PRIME;
    if (res >= PRIME) res = res - PRIME;
    return res;
  endfunction

  function automatic logic [255:0] rand_wide();
    logic [255:0] v;
    for (int i = 0; i < 8; i++) v[32*i +: 32] = $urandom;
    return v;
  endfunction

  // Mostly field elements, with values near p, near the top and small ones.
  function automatic logic [255:0] rand_operand();
    logic [255:0] v;
    case ($urandom_range(0, 9))
      0:       v = PRIME - 256'($urandom_range(0, 3));
      1:       v = ALL_ONES - 256'($urandom_range(0, 3));
      2:       v = 256'($urandom_range(0, 3));
      3:       v = rand_wide();
      default: begin
        v = rand_wide();
        if (v >= PRIME) v = v - PRIME;
      end
    endcase
    return v;
  endfunction

  // Checks results against the oldest expectation and records accepted items.
  always @(posedge clk) begin
    logic [255:0] want;
    if (!rst) begin
      if (done) begin
        if (pending_products.size() == 0) begin
          $error("result with no item outstanding");
          fail_count++;
        end else begin
          want = pending_products.pop_front();
          if (r_0 !== want[63:0]) begin
            $error("r_0 expected %h actual %h", want[63:0], r_0);
            fail_count++;
          end
          if (r_1 !== want[127:64]) begin
            $error("r_1 expected %h actual %h", want[127:64], r_1);
            fail_count++;
          end
          if (r_2 !== want[191:128]) begin
            $error("r_2 expected %h actual %h", want[191:128], r_2);
            fail_count++;
          end
          if (r_3 !== want[255:192]) begin
            $error("r_3 expected %h actual %h", want[255:192], r_3);
            fail_count++;
          end
        end
      end
      if (start && !busy)
        pending_products.push_back(mont_product(cmd, {x_3, x_2, x_1, x_0},
                                                {y_3, y_2, y_1, y_0}));
    end
  end

  // Drives one item from a negedge and holds it until taken.
  task automatic send_item(logic c, logic [255:0] a, logic [255:0] b);
    @(negedge clk);
    start = 1'b1;
    cmd = c;
    {x_3, x_2, x_1, x_0} = a;
    {y_3, y_2, y_1, y_0} = b;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Idle gap after an item: usually none, sometimes short, rarely long.
  task automatic idle_gap(bit quiet);
    int n;
    n = 0;
    if (!quiet && $urandom_range(0, 9) >= 6)
      n = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 40);
    if (n > 0) begin
      @(negedge clk);
      start = 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  function automatic void add_row(logic c, logic [255:0] a, logic [255:0] b,
                                  bit typed, logic [255:0] product);
    mont_row_t row;
    row.cmd = c;
    row.x = a;
    row.y = b;
    row.typed = typed;
    row.product = product;
    directed_rows.push_back(row);
  endfunction

  initial begin
    int quiet_left;
    rst = 1'b1;
    start = 1'b0;
    cmd = CMD_MUL;
    {x_3, x_2, x_1, x_0} = '0;
    {y_3, y_2, y_1, y_0} = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed rows: zero and p give zero outright; the rest use the predictor.
    add_row(CMD_MUL, '0, '0, 1'b1, '0);
    add_row(CMD_MUL, '0, ALL_ONES, 1'b1, '0);
    add_row(CMD_MUL, ALL_ONES, '0, 1'b1, '0);
    add_row(CMD_MUL, PRIME, 256'd12345, 1'b1, '0);
    add_row(CMD_SQR, PRIME, ALL_ONES, 1'b1, '0);
    add_row(CMD_SQR, '0, ALL_ONES, 1'b1, '0);
    add_row(CMD_MUL, 256'd1, 256'd1, 1'b0, '0);
    add_row(CMD_MUL, ALL_ONES, ALL_ONES, 1'b0, '0);
    add_row(CMD_SQR, ALL_ONES, '0, 1'b0, '0);
    add_row(CMD_MUL, PRIME - 1, PRIME - 1, 1'b0, '0);
    add_row(CMD_SQR, PRIME - 1, 256'd7, 1'b0, '0);
    add_row(CMD_MUL, PRIME + 1, ALL_ONES, 1'b0, '0);
    add_row(CMD_MUL, 256'd1 << 255, 256'd2, 1'b0, '0);
    add_row(CMD_MUL, 256'd1 << 256 - 64, PRIME - 1, 1'b0, '0);
    add_row(CMD_SQR, {4{64'h5555_5555_5555_5555}}, {4{64'hAAAA_AAAA_AAAA_AAAA}}, 1'b0, '0);
    add_row(CMD_MUL, {4{64'hAAAA_AAAA_AAAA_AAAA}}, {4{64'h5555_5555_5555_5555}}, 1'b0, '0);
    foreach (directed_rows[i]) begin
      if (directed_rows[i].typed &&
          mont_product(directed_rows[i].cmd, directed_rows[i].x, directed_rows[i].y)
          !== directed_rows[i].product) begin
        $error("predictor disagrees with typed row %0d", i);
        fail_count++;
      end
      send_item(directed_rows[i].cmd, directed_rows[i].x, directed_rows[i].y);
      idle_gap(1'b0);
    end

    // Random items, with stretches of back-to-back traffic.
    quiet_left = 0;
    for (int n = 0; n < 1300; n++) begin
      if (n == 650) begin
        @(negedge clk);
        start = 1'b0;
        while (pending_products.size() != 0) @(negedge clk);
      end
      if (quiet_left == 0 && $urandom_range(0, 19) == 0) quiet_left = $urandom_range(20, 60);
      send_item(1'($urandom_range(0, 1)), rand_operand(), rand_operand());
      idle_gap(quiet_left != 0);
      if (quiet_left != 0) quiet_left--;
    end
    @(negedge clk);
    start = 1'b0;

    while (pending_products.size() != 0) @(posedge clk);
    repeat (2 * LATENCY) @(posedge clk);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog for a hung pipeline.
  initial begin
    #2ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
